// File: src/pid_controller_filtered_derivative_unit_defines.svh
// assertion macros for the pid controller unit
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_UNIT_DEFINES_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, held off during reset
`define PIDFD_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pid unit assertion failed");

// next-cycle implication, held off during reset
`define PIDFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pid unit assertion failed");

`else

`define PIDFD_ASSERT_IMPL(name, clk, rst, ante, cons)
`define PIDFD_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: src/pidfd_pkg.sv
// types, codes and saturation helpers for the pid controller unit
`timescale 1ns / 1ps

package pidfd_pkg;

   // register indexes on the csr write channel
   typedef enum logic [2:0] {
      REG_PROP_GAIN       = 3'd0,
      REG_INTEG_STEP_GAIN = 3'd1,
      REG_DERIV_GAIN      = 3'd2,
      REG_FILTER_ALPHA    = 3'd3,
      REG_FILTER_ENABLE   = 3'd4,
      REG_OUTPUT_MIN      = 3'd5,
      REG_OUTPUT_MAX      = 3'd6
   } csr_index_type;

   // request command codes
   typedef enum logic {
      CMD_UPDATE = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   localparam int unsigned SampleWidth = 16;
   localparam int unsigned QWidth      = 32;
   localparam int unsigned AlphaWidth  = 18;
   localparam int unsigned WideWidth   = 51;
   localparam int unsigned QFrac       = 16;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic signed [QWidth-1:0]      q_type;
   typedef logic signed [AlphaWidth-1:0]  alpha_type;
   typedef logic signed [WideWidth-1:0]   wide_type;

   // saturate a wide sum into the q16.16 range
   function automatic q_type sat_q(input wide_type v);
      q_type res;
      if (v < wide_type'(q_type'({1'b1, {(QWidth-1){1'b0}}}))) begin
         res = {1'b1, {(QWidth-1){1'b0}}};
      end else if (v > wide_type'(q_type'({1'b0, {(QWidth-1){1'b1}}}))) begin
         res = {1'b0, {(QWidth-1){1'b1}}};
      end else begin
         res = v[QWidth-1:0];
      end
      return res;
   endfunction

   // clamp against the output limits; with crossed limits, values below lo give lo and all others hi
   function automatic q_type clamp_q(input wide_type v, input q_type lo, input q_type hi);
      q_type res;
      if (v < wide_type'(lo)) begin
         res = lo;
      end else if (v > wide_type'(hi)) begin
         res = hi;
      end else begin
         res = v[QWidth-1:0];
      end
      return res;
   endfunction

endpackage

// File: src/pid_controller_filtered_derivative_unit.sv
// pid controller with trapezoidal integrator and filtered derivative
// path: a request is held in the request register, then the math fills the result register,
//    which offers the result on rsp; an update waits while the result slot is full and not draining
// throughput: one request per cycle while the result slot is free or draining; the integrator and
//    derivative feedback close within the combinational math, which sets the rate
// a clear request resets the history and produces no result
// reset: synchronous, restores the registers to their defaults and clears the history
`timescale 1ns / 1ps
`include "pid_controller_filtered_derivative_unit_defines.svh"

module pid_controller_filtered_derivative_unit (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,   // target_value [15:0], measured_value [31:16]
   input  logic [0:0]               req_tuser,   // command [0]
   // result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // control_out [15:0]
   output logic [0:0]               rsp_tuser,   // was_clamped [0]
   // csr write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  pidfd_pkg::csr_index_type csr_index,
   input  logic [31:0]              csr_data
);
   import pidfd_pkg::*;

   // csr registers
   q_type      prop_gain_ff;
   q_type      integ_gain_ff;
   q_type      deriv_gain_ff;
   alpha_type  alpha_ff;
   logic       filt_en_ff;
   sample_type out_min_ff;
   sample_type out_max_ff;

   // request register
   logic       in_vld_ff;
   cmd_type    in_cmd_ff;
   sample_type in_target_ff;
   sample_type in_meas_ff;

   // controller history
   q_type                   integ_acc_ff,  integ_acc_in;
   logic signed [16:0]      last_err_ff;
   sample_type              last_meas_ff;
   q_type                   deriv_acc_ff,  deriv_acc_in;

   // result register
   logic       out_vld_ff;
   sample_type out_data_ff,  out_data_in;
   logic       out_clamp_ff, out_clamp_in;

   logic       adv;
   logic       is_clear;

   // datapath
   logic signed [16:0] err;
   logic signed [17:0] err_sum;
   logic signed [17:0] err_dif;
   logic signed [16:0] meas_dif;
   logic signed [48:0] p_prod;
   logic signed [49:0] inc;
   wide_type           integ_raw;
   q_type              lim_lo;
   q_type              lim_hi;
   q_type              integ_clamp;
   logic signed [49:0] alpha_prod;
   wide_type           alpha_rnd_sum;
   logic signed [34:0] alpha_rnd;
   logic signed [48:0] dm_prod;
   logic signed [49:0] de_prod;
   wide_type           d_raw;
   q_type              d_sat;
   wide_type           sum;
   q_type              sum_clamp;
   logic               clipped;
   wide_type           integ_back;
   q_type              rnd_sum;

   // math runs when the result slot is free or draining; clears need no slot
   assign is_clear   = (in_cmd_ff == CMD_CLEAR);
   assign adv        = in_vld_ff && (is_clear || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign csr_ready  = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= q_type'(32'sd65536);
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         alpha_ff      <= '0;
         filt_en_ff    <= 1'b0;
         out_min_ff    <= {1'b1, {(SampleWidth-1){1'b0}}};
         out_max_ff    <= {1'b0, {(SampleWidth-1){1'b1}}};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PROP_GAIN:       prop_gain_ff  <= csr_data;
            REG_INTEG_STEP_GAIN: integ_gain_ff <= csr_data;
            REG_DERIV_GAIN:      deriv_gain_ff <= csr_data;
            REG_FILTER_ALPHA:    alpha_ff      <= csr_data[AlphaWidth-1:0];
            REG_FILTER_ENABLE:   filt_en_ff    <= csr_data[0];
            REG_OUTPUT_MIN:      out_min_ff    <= csr_data[SampleWidth-1:0];
            REG_OUTPUT_MAX:      out_max_ff    <= csr_data[SampleWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff    <= cmd_type'(req_tuser[0]);
         in_target_ff <= req_tdata[15:0];
         in_meas_ff   <= req_tdata[31:16];
      end
   end

   // error terms
   always_comb begin
      err      = $signed({in_target_ff[15], in_target_ff}) - $signed({in_meas_ff[15], in_meas_ff});
      err_sum  = $signed({err[16], err}) + $signed({last_err_ff[16], last_err_ff});
      err_dif  = $signed({err[16], err}) - $signed({last_err_ff[16], last_err_ff});
      meas_dif = $signed({in_meas_ff[15], in_meas_ff})
               - $signed({last_meas_ff[15], last_meas_ff});
   end

   // products, all exact
   assign p_prod     = prop_gain_ff * err;
   assign inc        = integ_gain_ff * err_sum;
   assign alpha_prod = alpha_ff * deriv_acc_ff;
   assign dm_prod    = deriv_gain_ff * meas_dif;
   assign de_prod    = deriv_gain_ff * err_dif;

   // limits in q16.16
   assign lim_lo = $signed({out_min_ff, {QFrac{1'b0}}});
   assign lim_hi = $signed({out_max_ff, {QFrac{1'b0}}});

   always_comb begin
      // integrator step, clamped to the limits
      integ_raw   = wide_type'(integ_acc_ff) + wide_type'(inc);
      integ_clamp = clamp_q(integ_raw, lim_lo, lim_hi);

      // derivative: low-pass of measurement change, or plain error change
      alpha_rnd_sum = wide_type'(alpha_prod) + wide_type'(51'sd32768);
      alpha_rnd     = alpha_rnd_sum[WideWidth-1:QFrac];
      if (filt_en_ff) begin
         d_raw = wide_type'(alpha_rnd) - wide_type'(dm_prod);
      end else begin
         d_raw = wide_type'(de_prod);
      end
      d_sat = sat_q(d_raw);

      // output sum and clamp
      sum       = wide_type'(p_prod) + wide_type'(integ_clamp) + wide_type'(d_sat);
      sum_clamp = clamp_q(sum, lim_lo, lim_hi);
      clipped   = (sum != wide_type'(sum_clamp));

      // anti-windup: take the increment back when the output clipped
      integ_back = wide_type'(integ_clamp) - wide_type'(inc);
      if (clipped) begin
         integ_acc_in = sat_q(integ_back);
      end else begin
         integ_acc_in = integ_clamp;
      end
      deriv_acc_in = d_sat;

      // round half up to an integer sample; the clamp keeps this in range
      rnd_sum      = sum_clamp + q_type'(32'sd32768);
      out_data_in  = rnd_sum[QWidth-1:QFrac];
      out_clamp_in = clipped;
   end

   // history update
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_acc_ff <= '0;
         last_err_ff  <= '0;
         last_meas_ff <= '0;
         deriv_acc_ff <= '0;
      end else if (adv) begin
         if (is_clear) begin
            integ_acc_ff <= '0;
            last_err_ff  <= '0;
            last_meas_ff <= '0;
            deriv_acc_ff <= '0;
         end else begin
            integ_acc_ff <= integ_acc_in;
            last_err_ff  <= err;
            last_meas_ff <= in_meas_ff;
            deriv_acc_ff <= deriv_acc_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv && !is_clear) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && !is_clear) begin
         out_data_ff  <= out_data_in;
         out_clamp_ff <= out_clamp_in;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_clamp_ff;

   // a clear wipes the feedback state
   `PIDFD_ASSERT_NEXT(a_clear_wipes, clock, reset, adv && is_clear, integ_acc_ff == '0 && deriv_acc_ff == '0 && last_err_ff == '0)
   // an update always lands a result
   `PIDFD_ASSERT_NEXT(a_update_result, clock, reset, adv && !is_clear, out_vld_ff)
   // a clipped result sits on one of the limits
   `PIDFD_ASSERT_IMPL(a_clip_on_limit, clock, reset, out_vld_ff && out_clamp_ff, out_data_ff == out_min_ff || out_data_ff == out_max_ff)
   // with sane limits every result lies between them
   `PIDFD_ASSERT_IMPL(a_out_in_range, clock, reset, out_vld_ff && out_min_ff <= out_max_ff, out_data_ff >= out_min_ff && out_data_ff <= out_max_ff)

endmodule

// File: tb/sv/pidfd_result_checker.sv
// result checker for the pid controller unit: tracks registers, predicts and compares results
`timescale 1ns / 1ps

module pidfd_result_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [31:0]              req_tdata,   // target_value [15:0], measured_value [31:16]
   input  logic [0:0]               req_tuser,   // command [0]
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [15:0]              rsp_tdata,   // control_out [15:0]
   input  logic [0:0]               rsp_tuser,   // was_clamped [0]
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  pidfd_pkg::csr_index_type csr_index,
   input  logic [31:0]              csr_data,
   output int                       fail_count,
   output int                       outstanding,
   output int                       results_checked,
   output int                       clamped_results
);

   import pidfd_pkg::*;

   localparam int     MaxPrinted = 40;
   localparam longint QMax       = 64'sh0000_0000_7fff_ffff;
   localparam longint QMin       = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      sample_type control_out;
      logic       was_clamped;
   } pid_result_type;

   // register copies
   q_type      kp_gain;
   q_type      ki_step;
   q_type      kd_gain;
   alpha_type  lp_pole;
   logic       lp_on;
   sample_type lim_lo;
   sample_type lim_hi;

   // controller history
   q_type              integ_acc;
   logic signed [16:0] last_err;
   sample_type         prev_meas;
   q_type              deriv_acc;

   pid_result_type expected_results[$];
   pid_result_type seen_result;
   pid_result_type due_result;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MaxPrinted) begin
         $display("%0t ns  mismatch: %s", $time, msg);
      end
   endtask

   // x / 2^16 rounded half up
   function automatic longint round_half_up(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint saturate_q32(input longint x);
      if (x < QMin) return QMin;
      if (x > QMax) return QMax;
      return x;
   endfunction

   // lower bound checked first: with crossed limits, values below it give it, all others the upper bound
   function automatic longint clamp_to_limits(input longint v);
      longint lo;
      longint hi;
      lo = longint'(lim_lo) * 65536;
      hi = longint'(lim_hi) * 65536;
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void forget_history();
      integ_acc  = '0;
      last_err   = '0;
      prev_meas  = '0;
      deriv_acc  = '0;
   endfunction

   function automatic pid_result_type step_controller(input sample_type target,
                                                      input sample_type meas);
      longint         err;
      longint         inc;
      longint         integ;
      longint         d;
      longint         total;
      longint         bounded;
      pid_result_type res;
      err   = longint'(target) - longint'(meas);
      inc   = longint'(ki_step) * (err + longint'(last_err));
      integ = clamp_to_limits(longint'(integ_acc) + inc);
      if (lp_on) begin
         d = round_half_up(longint'(lp_pole) * longint'(deriv_acc))
             - longint'(kd_gain) * (longint'(meas) - longint'(prev_meas));
      end else begin
         d = longint'(kd_gain) * (err - longint'(last_err));
      end
      d         = saturate_q32(d);
      deriv_acc = q_type'(d);
      total     = longint'(kp_gain) * err + integ + d;
      bounded   = clamp_to_limits(total);
      res.was_clamped = (total != bounded);
      // back-calculation: drop this step's increment when the output clipped
      if (res.was_clamped) begin
         integ = integ - inc;
      end
      integ_acc  = q_type'(saturate_q32(integ));
      last_err   = err[16:0];
      prev_meas  = meas;
      res.control_out = sample_type'(round_half_up(bounded));
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp_gain = 32'sd65536;
         ki_step = '0;
         kd_gain = '0;
         lp_pole = '0;
         lp_on   = 1'b0;
         lim_lo  = 16'sh8000;
         lim_hi  = 16'sh7fff;
         forget_history();
         expected_results.delete();
         fail_count      = 0;
         outstanding     = 0;
         results_checked = 0;
         clamped_results = 0;
      end else begin
         // compare first so a result never meets an expectation pushed at the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen_result.control_out = rsp_tdata;
            seen_result.was_clamped = rsp_tuser[0];
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending, control_out %0d",
                                         $signed(seen_result.control_out)));
            end else begin
               due_result = expected_results.pop_front();
               results_checked++;
               if (due_result.was_clamped) clamped_results++;
               if (seen_result.control_out !== due_result.control_out) begin
                  report_mismatch($sformatf("control_out got %0d expected %0d",
                                            $signed(seen_result.control_out),
                                            $signed(due_result.control_out)));
               end
               if (seen_result.was_clamped !== due_result.was_clamped) begin
                  report_mismatch($sformatf("was_clamped got %0b expected %0b",
                                            seen_result.was_clamped,
                                            due_result.was_clamped));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PROP_GAIN:       kp_gain = csr_data;
               REG_INTEG_STEP_GAIN: ki_step = csr_data;
               REG_DERIV_GAIN:      kd_gain = csr_data;
               REG_FILTER_ALPHA:    lp_pole = csr_data[AlphaWidth-1:0];
               REG_FILTER_ENABLE:   lp_on   = csr_data[0];
               REG_OUTPUT_MIN:      lim_lo  = csr_data[SampleWidth-1:0];
               REG_OUTPUT_MAX:      lim_hi  = csr_data[SampleWidth-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (cmd_type'(req_tuser[0]) == CMD_CLEAR) begin
               forget_history();
            end else begin
               expected_results.push_back(step_controller(req_tdata[15:0], req_tdata[31:16]));
            end
         end
         outstanding = expected_results.size();
      end
   end

endmodule

// File: tb/sv/tb_top.sv
// top of the pid controller testbench: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_top;

   import pidfd_pkg::*;

   localparam int SettleCycles = 4;          // settling wait after the last result, for a trailing clear request
   localparam int HoldCycles   = 150;        // long receiver hold-off
   localparam int PhaseItems   = 100;
   localparam int RandomPhases = 10;
   localparam int RunLimitNs   = 5_000_000;  // many times the slowest legal run

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [31:0]   req_tdata;    // target_value [15:0], measured_value [31:16]
   logic [0:0]    req_tuser;    // command [0]
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [15:0]   rsp_tdata;    // control_out [15:0]
   logic [0:0]    rsp_tuser;    // was_clamped [0]
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [31:0]   csr_data;

   int fail_count;
   int outstanding;
   int results_checked;
   int clamped_results;

   int updates_sent;
   int clears_sent;
   int configs_loaded;

   // hold_request is shared between the stimulus and the receiver process; sender_steady is the stimulus's own
   bit hold_request;
   bit sender_steady;

   // slowly moving setpoint and process value for loop-like requests
   int setpoint;
   int plant_meas;

   pid_controller_filtered_derivative_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pidfd_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .clamped_results (clamped_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the unit hangs
   initial begin
      #(RunLimitNs);
      $display("run limit reached with %0d results still pending", outstanding);
      $display("pid_controller_filtered_derivative_unit verification failed");
      $finish;
   end

   // mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // gains: extremes, raw random words, and plausible small values of either sign
   function automatic int pick_gain();
      int r;
      int mag;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 0;
         3: return $urandom;
         default: begin
            mag = $urandom_range(0, 32'h0003_0000);
            return (r[0]) ? -mag : mag;
         end
      endcase
   endfunction

   // low-pass pole in q1.16, limited to [-1.0, 1.0]
   function automatic int pick_pole();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 65536;
         1: return -65536;
         2: return 0;
         3: return int'($urandom_range(0, 131072)) - 65536;
         default: return $urandom_range(32768, 65535);
      endcase
   endfunction

   // entered and left at a falling edge; tvalid stays high if the next request follows at once
   task automatic send_req(input cmd_type cmd, input int target, input int meas);
      int         gap;
      logic [15:0] target_bits;
      logic [15:0] meas_bits;
      gap         = sender_steady ? 0 : pick_gap();
      target_bits = 16'(target);
      meas_bits   = 16'(meas);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {meas_bits, target_bits};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (cmd == CMD_CLEAR) clears_sent++;
      else updates_sent++;
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_csr(input csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // drain: every result back, then a settling wait for a trailing clear request
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic load_config(input int kp, input int ki, input int kd, input int pole,
                              input int filt, input int lo, input int hi);
      wait_idle();
      write_csr(REG_PROP_GAIN, kp);
      write_csr(REG_INTEG_STEP_GAIN, ki);
      write_csr(REG_DERIV_GAIN, kd);
      write_csr(REG_FILTER_ALPHA, pole);
      write_csr(REG_FILTER_ENABLE, filt);
      write_csr(REG_OUTPUT_MIN, lo);
      write_csr(REG_OUTPUT_MAX, hi);
      csr_valid <= 1'b0;
      configs_loaded++;
   endtask

   task automatic shuffle_config();
      int r;
      int lo;
      int hi;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         // full range
         lo = -32768;
         hi = 32767;
      end else if (r == 1) begin
         // crossed limits: values below the lower bound give it, all others the upper bound
         lo = $urandom_range(1, 32767);
         hi = -int'($urandom_range(0, 32768));
      end else if (r == 2) begin
         // single allowed value
         lo = int'($urandom_range(0, 65535)) - 32768;
         hi = lo;
      end else begin
         lo = -int'($urandom_range(50, 32768));
         hi = $urandom_range(50, 32767);
      end
      load_config(pick_gain(), pick_gain(), pick_gain(), pick_pole(),
                  $urandom_range(0, 1), lo, hi);
   endtask

   // mostly a drifting process value against a held setpoint, some raw noise and clears
   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_req(CMD_CLEAR, $urandom, $urandom);
      end else if (r < 15) begin
         send_req(CMD_UPDATE, $urandom, $urandom);
      end else begin
         if (r < 22) setpoint = int'($urandom_range(0, 65535)) - 32768;
         plant_meas = plant_meas + int'($urandom_range(0, 600)) - 300;
         if (plant_meas > 32767) plant_meas = 32767;
         if (plant_meas < -32768) plant_meas = -32768;
         send_req(CMD_UPDATE, setpoint, plant_meas);
      end
   endtask

   // receiver: random stalls, stretches of steady readiness, and one long hold-off
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            // hold the result channel while requests keep coming, so the unit backs up
            rsp_tready <= 1'b0;
            hold_request = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 80)) @(negedge clock);
         else repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   // stimulus
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_valid      = 1'b0;
      csr_index      = REG_PROP_GAIN;
      csr_data       = '0;
      hold_request   = 1'b0;
      sender_steady  = 1'b0;
      updates_sent   = 0;
      clears_sent    = 0;
      configs_loaded = 0;
      setpoint       = 0;
      plant_meas     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: unit proportional gain, full-range limits
      send_req(CMD_UPDATE, 0, 0);
      send_req(CMD_UPDATE, 32767, -32768);
      send_req(CMD_UPDATE, -32768, 32767);
      send_req(CMD_UPDATE, 1234, 1000);
      send_req(CMD_CLEAR, -1, -1);
      send_req(CMD_UPDATE, -1, 0);

      // largest positive gains, most negative integrator step, filter pole at +1.0
      load_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 65536, 1, -32768, 32767);
      send_req(CMD_UPDATE, 32767, -32768);
      send_req(CMD_UPDATE, -32768, 32767);
      send_req(CMD_UPDATE, 0, 32767);
      send_req(CMD_UPDATE, 0, -32768);
      send_req(CMD_CLEAR, 32767, -32768);
      send_req(CMD_UPDATE, 5, 5);

      // most negative proportional and derivative gains, largest integrator step, pole at -1.0, crossed limits
      load_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, -65536, 1, 100, -100);
      send_req(CMD_UPDATE, 0, 0);
      send_req(CMD_UPDATE, 32767, -32768);
      send_req(CMD_UPDATE, -32768, 32767);

      // modest gains, unfiltered derivative, limits pinned to zero
      load_config(65536, 32'h1000, 32'h8000, 0, 0, 0, 0);
      send_req(CMD_UPDATE, 10, 0);
      send_req(CMD_UPDATE, 0, 10);

      // same gains with the filtered derivative, both limits at the most negative value
      load_config(65536, 32'h1000, 32'h8000, 32768, 1, -32768, -32768);
      send_req(CMD_UPDATE, 300, -300);
      send_req(CMD_UPDATE, 32767, 32767);

      // random phases, each with its own register settings
      for (int phase = 0; phase < RandomPhases; phase++) begin
         shuffle_config();
         sender_steady = ($urandom_range(0, 4) == 0);
         if (phase == RandomPhases / 2) begin
            hold_request  = 1'b1;
            sender_steady = 1'b1;
            // requests go out only once the receiver has started its hold-off
            while (hold_request) @(negedge clock);
         end
         if ($urandom_range(0, 1)) send_req(CMD_CLEAR, $urandom, $urandom);
         for (int n = 0; n < PhaseItems; n++) random_item();
      end

      wait_idle();
      repeat (4 * SettleCycles) @(negedge clock);

      $display("covered %0d update and %0d clear requests over %0d register settings",
               updates_sent, clears_sent, configs_loaded);
      $display("compared %0d results, %0d of them at an output limit",
               results_checked, clamped_results);
      if (fail_count == 0 && outstanding == 0) begin
         $display("pid_controller_filtered_derivative_unit verification clean");
      end else begin
         $display("pid_controller_filtered_derivative_unit verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/pidfd_pkg.sv
src/pid_controller_filtered_derivative_unit.sv
tb/sv/pidfd_result_checker.sv
tb/sv/tb_top.sv
